// File: rtl/mwir_pkg.sv
// Package: field widths, codes and stage record for the multi-width remainder block.
package mwir_pkg;
  localparam int DataW = 64;
  localparam int NStg = DataW / 4;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIV_ZERO = 2'd1,
    ST_BAD_SIZE = 2'd2
  } status_t;

  localparam logic [2:0] WC_8  = 3'd0;
  localparam logic [2:0] WC_16 = 3'd1;
  localparam logic [2:0] WC_32 = 3'd2;
  localparam logic [2:0] WC_64 = 3'd3;

  typedef struct packed {
    logic [DataW-1:0] rem;
    logic [DataW-1:0] div;
    logic [DataW-1:0] quo;
    logic [DataW-1:0] mask;
    logic             neg;
    status_t          status;
  } stage_t;

  function automatic logic [DataW-1:0] width_mask(input logic [1:0] code);
    logic [DataW-1:0] m;
    unique case (code)
      2'd0: m = 64'hFF;
      2'd1: m = 64'hFFFF;
      2'd2: m = 64'hFFFF_FFFF;
      default: m = '1;
    endcase
    return m;
  endfunction
endpackage

// File: rtl/multi_width_integer_remainder.sv
// Top level: pipelined multi-width signed/unsigned integer remainder.
// Path: input word passes the prep register, the divider stages and the post register to the result.
// Throughput: one word per cycle unless stalled; the 16 four-bit divider stages set depth.
// Whole pipeline advances together; out_tready low while out_tvalid is high stalls every stage.
// Reset: synchronous active-low rst_n clears all valid bits.
module multi_width_integer_remainder import mwir_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // dividend[63:0], divisor[127:64], width_code[130:128], unsigned_mode[131], zero pad
  input  logic [135:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // remainder[63:0], status[65:64], zero pad
  output logic [71:0]  out_tdata
);
  logic             en;
  logic             vld [NStg+1];
  stage_t           st  [NStg+1];
  logic [DataW-1:0] rem;
  status_t          stat;

  assign en = !out_tvalid || out_tready;
  assign in_tready = en;

  mwir_prep u_prep (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(in_tvalid),
    .dividend(in_tdata[63:0]), .divisor(in_tdata[127:64]),
    .width_code(in_tdata[130:128]), .unsigned_mode(in_tdata[131]),
    .out_vld(vld[0]), .out_st(st[0])
  );

  for (genvar g = 0; g < NStg; g++) begin : g_div
    mwir_div_stage u_stg (
      .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld[g]), .in_st(st[g]),
      .out_vld(vld[g+1]), .out_st(st[g+1])
    );
  end

  mwir_post u_post (
    .clk(clk), .rst_n(rst_n), .en(en), .in_vld(vld[NStg]), .in_st(st[NStg]),
    .out_vld(out_tvalid), .remainder(rem), .status(stat)
  );

  assign out_tdata = {6'd0, stat, rem};

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[65:64] != ST_OK |-> out_tdata[63:0] == '0)
    else $error("error result not zero");
  a_bad_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[65:64] != 2'd3)
    else $error("undefined status code");
endmodule

// File: rtl/mwir_prep.sv
// Input stage: mask operands, take magnitudes and classify errors.
module mwir_prep import mwir_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  logic [DataW-1:0] dividend,
  input  logic [DataW-1:0] divisor,
  input  logic [2:0]       width_code,
  input  logic             unsigned_mode,
  output logic             out_vld,
  output stage_t           out_st
);
  logic [DataW-1:0] mask, sign, a, b, ma, mb;
  logic             na, nb;
  stage_t           st_nxt, st_r;
  logic             vld_r;

  always_comb begin
    mask = width_mask(width_code[1:0]);
    sign = (mask >> 1) + 64'd1;
    a = dividend & mask;
    b = divisor & mask;
    na = !unsigned_mode && ((a & sign) != '0);
    nb = !unsigned_mode && ((b & sign) != '0);
    ma = na ? ((~a + 64'd1) & mask) : a;
    mb = nb ? ((~b + 64'd1) & mask) : b;
    st_nxt.rem = '0;
    st_nxt.div = mb;
    st_nxt.quo = ma;
    st_nxt.mask = mask;
    st_nxt.neg = na;
    if (width_code[2]) begin
      st_nxt.status = ST_BAD_SIZE;
    end else if (b == '0) begin
      st_nxt.status = ST_DIV_ZERO;
    end else begin
      st_nxt.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_st = st_r;
endmodule

// File: rtl/mwir_div_stage.sv
// One pipeline stage of restoring division: four quotient bits a stage.
module mwir_div_stage import mwir_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   en,
  input  logic   in_vld,
  input  stage_t in_st,
  output logic   out_vld,
  output stage_t out_st
);
  stage_t st_nxt, st_r;
  logic   vld_r;
  logic [DataW:0] t;

  always_comb begin
    st_nxt = in_st;
    t = '0;
    for (int i = 0; i < 4; i++) begin
      t = {st_nxt.rem, st_nxt.quo[DataW-1]};
      st_nxt.quo = {st_nxt.quo[DataW-2:0], 1'b0};
      if (t >= {1'b0, st_nxt.div}) begin
        t = t - {1'b0, st_nxt.div};
      end
      st_nxt.rem = t[DataW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      st_r <= st_nxt;
    end
  end

  assign out_vld = vld_r;
  assign out_st = st_r;
endmodule

// File: rtl/mwir_post.sv
// Output stage: apply dividend sign, mask and error overrides.
module mwir_post import mwir_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_vld,
  input  stage_t           in_st,
  output logic             out_vld,
  output logic [DataW-1:0] remainder,
  output status_t          status
);
  logic [DataW-1:0] rem_nxt, rem_r;
  status_t          stat_r;
  logic             vld_r;

  always_comb begin
    rem_nxt = in_st.neg ? ((~in_st.rem + 64'd1) & in_st.mask) : in_st.rem;
    if (in_st.status != ST_OK) begin
      rem_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
    if (en) begin
      rem_r <= rem_nxt;
      stat_r <= in_st.status;
    end
  end

  assign out_vld = vld_r;
  assign remainder = rem_r;
  assign status = stat_r;
endmodule
